// ===== src/script_subset_tokenizer_assert.svh =====
// assertion macros shared by the tokenizer modules
`ifndef SCRIPT_SUBSET_TOKENIZER_ASSERT_SVH
`define SCRIPT_SUBSET_TOKENIZER_ASSERT_SVH

// condition implies property in the same cycle
`define SST_CHECK(name, pre, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (prop)) \
		else $error(msg);

// condition implies property in the next cycle
`define SST_CHECK_NEXT(name, pre, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/sst_pkg.sv =====
// types, constants and helper functions of the tokenizer
package sst_pkg;

	localparam int MAX_VALUE_LEN_DEF = 4096;
	localparam int MAX_RES = 4;
	localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

	typedef enum logic [4:0] {
		M_GAP    = 5'd0,
		M_SLASH  = 5'd1,
		M_LCOM   = 5'd2,
		M_BCOM   = 5'd3,
		M_BSTAR  = 5'd4,
		M_LT     = 5'd5,
		M_TAG    = 5'd6,
		M_QUEST  = 5'd7,
		M_STR    = 5'd8,
		M_STRESC = 5'd9,
		M_NUM    = 5'd10,
		M_NUMEXP = 5'd11,
		M_DOLLAR = 5'd12,
		M_VAR    = 5'd13,
		M_DYN    = 5'd14,
		M_WORD   = 5'd15,
		M_EQ1    = 5'd16,
		M_EQ2    = 5'd17,
		M_OP2    = 5'd18,
		M_DONE   = 5'd19
	} mode_t;

	localparam logic [5:0] K_NONE     = 6'd0;
	localparam logic [5:0] K_END      = 6'd0;
	localparam logic [5:0] K_OPEN     = 6'd1;
	localparam logic [5:0] K_CLOSE    = 6'd2;
	localparam logic [5:0] K_INT      = 6'd3;
	localparam logic [5:0] K_FLOAT    = 6'd4;
	localparam logic [5:0] K_STRING   = 6'd5;
	localparam logic [5:0] K_VAR      = 6'd6;
	localparam logic [5:0] K_DYNVAR   = 6'd7;
	localparam logic [5:0] K_ECHO     = 6'd8;
	localparam logic [5:0] K_IF       = 6'd9;
	localparam logic [5:0] K_ELSE     = 6'd10;
	localparam logic [5:0] K_WHILE    = 6'd11;
	localparam logic [5:0] K_FOR      = 6'd12;
	localparam logic [5:0] K_ASSIGN   = 6'd13;
	localparam logic [5:0] K_ADD_EQ   = 6'd14;
	localparam logic [5:0] K_SUB_EQ   = 6'd15;
	localparam logic [5:0] K_CAT_EQ   = 6'd16;
	localparam logic [5:0] K_PLUS     = 6'd17;
	localparam logic [5:0] K_MINUS    = 6'd18;
	localparam logic [5:0] K_STAR     = 6'd19;
	localparam logic [5:0] K_SLASH    = 6'd20;
	localparam logic [5:0] K_PERCENT  = 6'd21;
	localparam logic [5:0] K_DOT      = 6'd22;
	localparam logic [5:0] K_EQ       = 6'd23;
	localparam logic [5:0] K_NE       = 6'd24;
	localparam logic [5:0] K_IDENT    = 6'd25;
	localparam logic [5:0] K_LT       = 6'd26;
	localparam logic [5:0] K_GT       = 6'd27;
	localparam logic [5:0] K_LE       = 6'd28;
	localparam logic [5:0] K_GE       = 6'd29;
	localparam logic [5:0] K_NOT      = 6'd30;
	localparam logic [5:0] K_SEMI     = 6'd31;
	localparam logic [5:0] K_COMMA    = 6'd32;
	localparam logic [5:0] K_LBRACE   = 6'd33;
	localparam logic [5:0] K_RBRACE   = 6'd34;
	localparam logic [5:0] K_LPAREN   = 6'd35;
	localparam logic [5:0] K_RPAREN   = 6'd36;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_OPEN_COM = 3'd1;
	localparam logic [2:0] E_BAD_TAG  = 3'd2;
	localparam logic [2:0] E_EMPTY    = 3'd3;
	localparam logic [2:0] E_UNKNOWN  = 3'd4;
	localparam logic [2:0] E_BAD_CHAR = 3'd5;
	localparam logic [2:0] E_TOO_LONG = 3'd6;

	localparam logic [39:0] KW_ECHO  = 40'h006563686F;
	localparam logic [39:0] KW_IF    = 40'h0000006966;
	localparam logic [39:0] KW_ELSE  = 40'h00656C7365;
	localparam logic [39:0] KW_WHILE = 40'h7768696C65;
	localparam logic [39:0] KW_FOR   = 40'h0000666F72;
	localparam logic [39:0] TAG_PHP  = 40'h0000706870;

	typedef struct packed {
		logic digit;
		logic alpha;
		logic space;
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		cls_t       cls;
	} item_t;

	typedef struct packed {
		logic [7:0]  value_byte;
		logic        has_byte;
		logic        token_done;
		logic [5:0]  token_kind;
		logic [23:0] token_line;
		logic [2:0]  error_code;
		logic        last_of_step;
	} res_t;

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"*": k = K_STAR;
			"%": k = K_PERCENT;
			";": k = K_SEMI;
			",": k = K_COMMA;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] first, input logic with_eq);
		logic [5:0] k;
		case (first)
			"!": k = with_eq ? K_NE : K_NOT;
			">": k = with_eq ? K_GE : K_GT;
			"+": k = with_eq ? K_ADD_EQ : K_PLUS;
			"-": k = with_eq ? K_SUB_EQ : K_MINUS;
			default: k = with_eq ? K_CAT_EQ : K_DOT;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] kw_kind(input logic [39:0] w);
		logic [5:0] k;
		k = K_NONE;
		if (w == KW_ECHO) k = K_ECHO;
		if (w == KW_IF) k = K_IF;
		if (w == KW_ELSE) k = K_ELSE;
		if (w == KW_WHILE) k = K_WHILE;
		if (w == KW_FOR) k = K_FOR;
		return k;
	endfunction

endpackage

// ===== src/script_subset_tokenizer.sv =====
// top level of the streaming script tokenizer
// Source bytes enter on the byte channel (byte_valid, byte_stall, input_byte,
// end_of_input) and tokens leave on the token channel (token_valid,
// token_stall and the result fields). A transfer happens at a clock edge where
// valid is high and stall is low.
// Each source byte gives zero to four results: value bytes of strings, numbers
// and names, a token_done result carrying kind and start line, or an error.
// last_of_step marks the final result belonging to one source byte.
// A byte passes through the input queue before it reaches the lexer, and its
// results are registered in the result queue before they appear at the output.
// Throughput: while token_stall stays low, one byte per cycle if each byte gives
// at most one result; a byte with more results holds the lexer while the
// four-entry result queue drains one result per cycle. A two-entry input queue
// decouples the sides, so token stalls back up to byte_stall after two bytes.
// After an error the block swallows all bytes silently until reset.
// Reset (arst_n low) empties both queues and returns the lexer to the
// between-tokens mode at line one.
module script_subset_tokenizer #(
	parameter int MAX_VALUE_LEN = sst_pkg::MAX_VALUE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  input_byte,
	input  logic        end_of_input,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [7:0]  value_byte,
	output logic        has_byte,
	output logic        token_done,
	output logic [5:0]  token_kind,
	output logic [23:0] token_line,
	output logic [2:0]  error_code,
	output logic        last_of_step
);

	logic           item_valid;
	logic           item_take;
	sst_pkg::item_t item;
	sst_pkg::res_t  res;

	sst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.input_byte   (input_byte),
		.end_of_input (end_of_input),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	sst_back #(
		.MAX_VALUE_LEN (MAX_VALUE_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.res         (res)
	);

	assign value_byte   = res.value_byte;
	assign has_byte     = res.has_byte;
	assign token_done   = res.token_done;
	assign token_kind   = res.token_kind;
	assign token_line   = res.token_line;
	assign error_code   = res.error_code;
	assign last_of_step = res.last_of_step;

endmodule

// ===== src/sst_front.sv =====
// front end: accepts source bytes, classifies them and queues them
`include "script_subset_tokenizer_assert.svh"
module sst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        input_byte,
	input  logic              end_of_input,
	output logic              item_valid,
	output sst_pkg::item_t    item,
	input  logic              item_take
);

	sst_pkg::item_t q_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	sst_pkg::item_t in_item;

	assign byte_stall = (cnt_q == 2'd2);
	assign push       = byte_valid && !byte_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_q[rd_q];

	always_comb begin
		in_item.ch        = input_byte;
		in_item.eoi       = end_of_input;
		in_item.cls.digit = (input_byte >= "0") && (input_byte <= "9");
		in_item.cls.alpha = ((input_byte >= "a") && (input_byte <= "z")) ||
			((input_byte >= "A") && (input_byte <= "Z"));
		in_item.cls.space = (input_byte == " ") ||
			((input_byte >= 8'd9) && (input_byte <= 8'd13));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (item_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= in_item;
	end

	`SST_CHECK(a_no_take_empty, item_take, cnt_q != 2'd0, "take from empty queue")

endmodule

// ===== src/sst_back.sv =====
// back end: lexer state machine and result queue
`include "script_subset_tokenizer_assert.svh"
module sst_back #(
	parameter int MAX_VALUE_LEN = sst_pkg::MAX_VALUE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  sst_pkg::item_t    item,
	output logic              item_take,
	output logic              token_valid,
	input  logic              token_stall,
	output sst_pkg::res_t     res
);

	localparam int LEN_W = $clog2(MAX_VALUE_LEN);
	localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(MAX_VALUE_LEN - 1);

	typedef struct packed {
		sst_pkg::mode_t   mode;
		logic [7:0]       held;
		logic [23:0]      line;
		logic [23:0]      sline;
		logic [39:0]      word;
		logic [LEN_W-1:0] len;
		logic [1:0]       nflag;
		logic             qs;
		logic             err;
	} lex_t;

	lex_t          st_q;
	lex_t          st_d;
	sst_pkg::res_t rs [4];
	logic [2:0]    n_d;
	sst_pkg::res_t buf_q [4];
	logic [2:0]    cnt_q;
	logic          out_xfer;

	function automatic void push(inout sst_pkg::res_t r [4], inout logic [2:0] n,
		input sst_pkg::res_t x);
		if (n < 3'd4) begin
			r[n[1:0]] = x;
			n = n + 3'd1;
		end
	endfunction

	function automatic sst_pkg::res_t mk(input logic [7:0] v, input logic h, input logic d,
		input logic [5:0] k, input logic [23:0] ln, input logic [2:0] e);
		sst_pkg::res_t x;
		x.value_byte   = v;
		x.has_byte     = h;
		x.token_done   = d;
		x.token_kind   = k;
		x.token_line   = ln;
		x.error_code   = e;
		x.last_of_step = 1'b0;
		return x;
	endfunction

	function automatic void fail(inout lex_t s, inout sst_pkg::res_t r [4],
		inout logic [2:0] n, input logic [2:0] code);
		if (!s.err) begin
			push(r, n, mk(8'd0, 1'b0, 1'b0, sst_pkg::K_NONE, s.line, code));
			s.err = 1'b1;
		end
	endfunction

	function automatic void put_val(inout lex_t s, inout sst_pkg::res_t r [4],
		inout logic [2:0] n, input logic [7:0] b);
		if (!s.err) begin
			if (s.len >= LEN_LIM) fail(s, r, n, sst_pkg::E_TOO_LONG);
			else begin
				push(r, n, mk(b, 1'b1, 1'b0, sst_pkg::K_NONE, s.sline, sst_pkg::E_NONE));
				s.len = s.len + 1'b1;
			end
		end
	endfunction

	function automatic void tok(inout lex_t s, inout sst_pkg::res_t r [4],
		inout logic [2:0] n, input logic [5:0] k);
		push(r, n, mk(8'd0, 1'b0, 1'b1, k, s.sline, sst_pkg::E_NONE));
	endfunction

	assign item_take = item_valid &&
		((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_xfer));

	// one source item, up to four passes through the mode decoder
	always_comb begin
		lex_t          s;
		logic          eoi;
		logic [7:0]    cb;
		logic          dg;
		logic          al;
		logic          sp;
		logic          idn;
		logic          go;
		logic          again;
		logic [5:0]    kw;
		sst_pkg::res_t r [4];
		logic [2:0]    n;
		s     = st_q;
		eoi   = item.eoi;
		cb    = eoi ? 8'd0 : item.ch;
		dg    = !eoi && item.cls.digit;
		al    = !eoi && item.cls.alpha;
		sp    = !eoi && item.cls.space;
		idn   = dg || al || (cb == "_");
		n     = 3'd0;
		go    = !s.err;
		again = 1'b0;
		kw    = sst_pkg::K_NONE;
		for (int i = 0; i < 4; i++) r[i] = mk(8'd0, 1'b0, 1'b0, sst_pkg::K_NONE, 24'd0,
			sst_pkg::E_NONE);
		if (go && !eoi) begin
			if (s.mode == sst_pkg::M_DONE) go = 1'b0;
			else if ((cb == 8'h0A) && (s.line != sst_pkg::LINE_TOP)) s.line = s.line + 24'd1;
		end
		for (int p = 0; p < 4; p++) begin
			if (go) begin
				again = 1'b0;
				unique case (s.mode)
					sst_pkg::M_GAP: begin
						if (eoi) begin
							push(r, n, mk(8'd0, 1'b0, 1'b1, sst_pkg::K_END, s.line,
								sst_pkg::E_NONE));
							s.mode = sst_pkg::M_DONE;
						end else if (!sp) begin
							s.sline = s.line;
							s.len   = '0;
							if (cb == "/") s.mode = sst_pkg::M_SLASH;
							else if (cb == "#") s.mode = sst_pkg::M_LCOM;
							else if (cb == "<") s.mode = sst_pkg::M_LT;
							else if (cb == "?") s.mode = sst_pkg::M_QUEST;
							else if ((cb == "\"") || (cb == "'")) begin
								s.qs   = (cb == "'");
								s.mode = sst_pkg::M_STR;
							end else if (cb == "$") s.mode = sst_pkg::M_DOLLAR;
							else if (cb == "=") s.mode = sst_pkg::M_EQ1;
							else if ((cb == "!") || (cb == ">") || (cb == "+") ||
								(cb == "-") || (cb == ".")) begin
								s.held = cb;
								s.mode = sst_pkg::M_OP2;
							end else if (dg) begin
								s.nflag = 2'd0;
								s.mode  = sst_pkg::M_NUM;
								put_val(s, r, n, cb);
							end else if (al || (cb == "_")) begin
								s.word = {32'd0, cb};
								s.len  = LEN_W'(1);
								s.mode = sst_pkg::M_WORD;
							end else if (sst_pkg::punct_kind(cb) != sst_pkg::K_NONE)
								tok(s, r, n, sst_pkg::punct_kind(cb));
							else fail(s, r, n, sst_pkg::E_BAD_CHAR);
						end
					end
					sst_pkg::M_SLASH: begin
						if (cb == "/") s.mode = sst_pkg::M_LCOM;
						else if (cb == "*") s.mode = sst_pkg::M_BCOM;
						else begin
							tok(s, r, n, sst_pkg::K_SLASH);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_LCOM: begin
						if (eoi) begin
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end else if (cb == 8'h0A) s.mode = sst_pkg::M_GAP;
					end
					sst_pkg::M_BCOM, sst_pkg::M_BSTAR: begin
						if (eoi) fail(s, r, n, sst_pkg::E_OPEN_COM);
						else if ((s.mode == sst_pkg::M_BSTAR) && (cb == "/"))
							s.mode = sst_pkg::M_GAP;
						else s.mode = (cb == "*") ? sst_pkg::M_BSTAR : sst_pkg::M_BCOM;
					end
					sst_pkg::M_LT: begin
						if (cb == "?") begin
							s.word = '0;
							s.len  = '0;
							s.mode = sst_pkg::M_TAG;
						end else if (cb == "=") begin
							tok(s, r, n, sst_pkg::K_LE);
							s.mode = sst_pkg::M_GAP;
						end else begin
							tok(s, r, n, sst_pkg::K_LT);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_TAG: begin
						if (al) begin
							if (s.len >= LEN_W'(3)) fail(s, r, n, sst_pkg::E_BAD_TAG);
							else begin
								s.word = {s.word[31:0], cb};
								s.len  = s.len + 1'b1;
							end
						end else if ((s.len == LEN_W'(3)) && (s.word == sst_pkg::TAG_PHP)) begin
							tok(s, r, n, sst_pkg::K_OPEN);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end else fail(s, r, n, sst_pkg::E_BAD_TAG);
					end
					sst_pkg::M_QUEST: begin
						if (cb == ">") begin
							tok(s, r, n, sst_pkg::K_CLOSE);
							s.mode = sst_pkg::M_GAP;
						end else fail(s, r, n, sst_pkg::E_BAD_CHAR);
					end
					sst_pkg::M_STR: begin
						if (eoi || (cb == (s.qs ? 8'h27 : 8'h22))) begin
							tok(s, r, n, sst_pkg::K_STRING);
							s.mode = sst_pkg::M_GAP;
							again  = eoi;
						end else if (cb == "\\") s.mode = sst_pkg::M_STRESC;
						else put_val(s, r, n, cb);
					end
					sst_pkg::M_STRESC: begin
						if (eoi) begin
							tok(s, r, n, sst_pkg::K_STRING);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end else begin
							s.mode = sst_pkg::M_STR;
							if (s.qs) begin
								if ((cb == "'") || (cb == "\\")) put_val(s, r, n, cb);
								else begin
									put_val(s, r, n, "\\");
									put_val(s, r, n, cb);
								end
							end else begin
								if (cb == "n") put_val(s, r, n, 8'h0A);
								else if (cb == "t") put_val(s, r, n, 8'h09);
								else if (cb == "r") put_val(s, r, n, 8'h0D);
								else if ((cb == "\"") || (cb == "\\") || (cb == "$"))
									put_val(s, r, n, cb);
								else begin
									put_val(s, r, n, "\\");
									put_val(s, r, n, cb);
								end
							end
						end
					end
					sst_pkg::M_NUM: begin
						if (dg) put_val(s, r, n, cb);
						else if ((cb == ".") && (s.nflag == 2'd0)) begin
							s.nflag[0] = 1'b1;
							put_val(s, r, n, cb);
						end else if (((cb == "e") || (cb == "E")) && !s.nflag[1]) begin
							s.nflag[1] = 1'b1;
							put_val(s, r, n, cb);
							s.mode = sst_pkg::M_NUMEXP;
						end else begin
							tok(s, r, n, (s.nflag != 2'd0) ? sst_pkg::K_FLOAT : sst_pkg::K_INT);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_NUMEXP: begin
						s.mode = sst_pkg::M_NUM;
						if ((cb == "+") || (cb == "-")) put_val(s, r, n, cb);
						else again = 1'b1;
					end
					sst_pkg::M_DOLLAR: begin
						s.len = '0;
						if (cb == "$") s.mode = sst_pkg::M_DYN;
						else begin
							s.mode = sst_pkg::M_VAR;
							again  = 1'b1;
						end
					end
					sst_pkg::M_VAR, sst_pkg::M_DYN: begin
						if (idn) put_val(s, r, n, cb);
						else if (s.len == '0) fail(s, r, n, sst_pkg::E_EMPTY);
						else begin
							tok(s, r, n, (s.mode == sst_pkg::M_DYN) ? sst_pkg::K_DYNVAR :
								sst_pkg::K_VAR);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_WORD: begin
						if (idn) begin
							if (s.len >= LEN_W'(5)) fail(s, r, n, sst_pkg::E_UNKNOWN);
							else begin
								s.word = {s.word[31:0], cb};
								s.len  = s.len + 1'b1;
							end
						end else begin
							kw = sst_pkg::kw_kind(s.word);
							if (kw == sst_pkg::K_NONE) fail(s, r, n, sst_pkg::E_UNKNOWN);
							else begin
								tok(s, r, n, kw);
								s.mode = sst_pkg::M_GAP;
								again  = 1'b1;
							end
						end
					end
					sst_pkg::M_EQ1: begin
						if (cb == "=") s.mode = sst_pkg::M_EQ2;
						else begin
							tok(s, r, n, sst_pkg::K_ASSIGN);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_EQ2: begin
						if (cb == "=") begin
							tok(s, r, n, sst_pkg::K_IDENT);
							s.mode = sst_pkg::M_GAP;
						end else begin
							tok(s, r, n, sst_pkg::K_EQ);
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					sst_pkg::M_OP2: begin
						if (cb == "=") begin
							tok(s, r, n, sst_pkg::op_kind(s.held, 1'b1));
							s.mode = sst_pkg::M_GAP;
						end else begin
							tok(s, r, n, sst_pkg::op_kind(s.held, 1'b0));
							s.mode = sst_pkg::M_GAP;
							again  = 1'b1;
						end
					end
					default: begin
						if (eoi) push(r, n, mk(8'd0, 1'b0, 1'b1, sst_pkg::K_END, s.line,
							sst_pkg::E_NONE));
					end
				endcase
				go = again && !s.err;
			end
		end
		if (n != 3'd0) r[2'(n - 3'd1)].last_of_step = 1'b1;
		st_d = s;
		n_d  = n;
		for (int i = 0; i < 4; i++) rs[i] = r[i];
	end

	assign out_xfer    = token_valid && !token_stall;
	assign token_valid = (cnt_q != 3'd0);
	assign res         = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode  <= sst_pkg::M_GAP;
			st_q.held  <= 8'd0;
			st_q.line  <= 24'd1;
			st_q.sline <= 24'd1;
			st_q.word  <= 40'd0;
			st_q.len   <= '0;
			st_q.nflag <= 2'd0;
			st_q.qs    <= 1'b0;
			st_q.err   <= 1'b0;
			cnt_q      <= 3'd0;
		end else begin
			if (item_take) begin
				st_q  <= st_d;
				cnt_q <= n_d;
			end else if (out_xfer) cnt_q <= cnt_q - 3'd1;
		end
	end

	// result queue shifts toward the head on each output transfer, unless a new item's results load it
	always_ff @(posedge clk) begin
		if (item_take) begin
			for (int i = 0; i < 4; i++) buf_q[i] <= rs[i];
		end else if (out_xfer) begin
			for (int i = 0; i < 3; i++) buf_q[i] <= buf_q[i + 1];
		end
	end

	`SST_CHECK(a_cnt_range, 1'b1, cnt_q <= 3'd4, "result count out of range")
	`SST_CHECK(a_take_when_free, item_take, (cnt_q == 3'd0) || out_xfer, "load over pending results")
	`SST_CHECK_NEXT(a_halt_silent, item_take && st_q.err, cnt_q == 3'd0, "results after error")

endmodule

// ===== verif/tb_top.sv =====
// testbench for the script tokenizer: random token streams checked against a built-in lexer model
`timescale 1ns / 1ps

module tb_top;
	import sst_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	// short value limit so the too-long ending stays a few dozen bytes
	localparam int VALUE_LEN = 64;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} src_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  input_byte;
	logic        end_of_input;
	logic        token_valid;
	logic        token_stall;
	logic [7:0]  value_byte;
	logic        has_byte;
	logic        token_done;
	logic [5:0]  token_kind;
	logic [23:0] token_line;
	logic [2:0]  error_code;
	logic        last_of_step;

	script_subset_tokenizer #(
		.MAX_VALUE_LEN (VALUE_LEN)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.input_byte(input_byte), .end_of_input(end_of_input),
		.token_valid(token_valid), .token_stall(token_stall),
		.value_byte(value_byte), .has_byte(has_byte), .token_done(token_done),
		.token_kind(token_kind), .token_line(token_line), .error_code(error_code),
		.last_of_step(last_of_step)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	src_t   src_q[$];
	res_t   tokens_due[$];
	res_t   step_res[$];
	int     errors = 0;
	int     bytes_sent = 0;
	int     results_seen = 0;
	int     tokens_seen = 0;
	int     cycles = 0;
	bit     calm = 0;
	bit     holdoff_done = 0;
	int     holdoff_cnt = 0;
	int     in_gap = 0;
	int     out_gap = 0;

	// lexer model state
	mode_t       lx_mode;
	logic [7:0]  lx_held;
	bit          lx_held_v;
	logic [23:0] lx_line;
	logic [23:0] lx_start;
	logic [39:0] lx_word;
	int unsigned lx_len;
	bit [1:0]    lx_nflags;
	bit          lx_single;
	bit          lx_halted;

	function automatic bit is_dig(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_let(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_idc(int c);
		return is_let(c) || is_dig(c) || c == "_";
	endfunction

	function automatic bit is_ws(int c);
		return c == " " || (c >= 9 && c <= 13);
	endfunction

	function automatic logic [5:0] glyph_kind(int c);
		case (c)
			"*": return K_STAR;
			"%": return K_PERCENT;
			";": return K_SEMI;
			",": return K_COMMA;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(logic [7:0] first, bit eq);
		case (first)
			"!": return eq ? K_NE : K_NOT;
			">": return eq ? K_GE : K_GT;
			"+": return eq ? K_ADD_EQ : K_PLUS;
			"-": return eq ? K_SUB_EQ : K_MINUS;
			default: return eq ? K_CAT_EQ : K_DOT;
		endcase
	endfunction

	function void add_res(logic [7:0] v, bit hb, bit dn, logic [5:0] k, logic [23:0] ln,
			logic [2:0] e);
		res_t r;
		if (step_res.size() >= MAX_RES) return;
		r.value_byte = v; r.has_byte = hb; r.token_done = dn; r.token_kind = k;
		r.token_line = ln; r.error_code = e; r.last_of_step = 1'b0;
		step_res.push_back(r);
	endfunction

	function void raise(logic [2:0] e);
		if (lx_halted) return;
		add_res(8'd0, 0, 0, K_NONE, lx_line, e);
		lx_halted = 1;
	endfunction

	function void close_tok(logic [5:0] k);
		add_res(8'd0, 0, 1, k, lx_start, E_NONE);
	endfunction

	function void val_out(logic [7:0] b);
		if (lx_halted) return;
		if (lx_len >= VALUE_LEN - 1) begin
			raise(E_TOO_LONG);
			return;
		end
		add_res(b, 1, 0, K_NONE, lx_start, E_NONE);
		lx_len++;
	endfunction

	function void back_to_gap();
		lx_mode = M_GAP;
		lx_held_v = 0;
	endfunction

	// one pass over a byte (c >= 0) or end mark (c < 0); 1 means look at it again
	function bit lex_pass(int c);
		logic [5:0] k;
		case (lx_mode)
			M_GAP: begin
				if (c < 0) begin
					add_res(8'd0, 0, 1, K_END, lx_line, E_NONE);
					lx_mode = M_DONE;
					return 0;
				end
				if (is_ws(c)) return 0;
				lx_start = lx_line;
				lx_len = 0;
				if (c == "/") lx_mode = M_SLASH;
				else if (c == "#") lx_mode = M_LCOM;
				else if (c == "<") lx_mode = M_LT;
				else if (c == "?") lx_mode = M_QUEST;
				else if (c == "\"" || c == "'") begin
					lx_single = (c == "'");
					lx_mode = M_STR;
				end else if (c == "$") lx_mode = M_DOLLAR;
				else if (c == "=") lx_mode = M_EQ1;
				else if (c == "!" || c == ">" || c == "+" || c == "-" || c == ".") begin
					lx_held = c[7:0];
					lx_held_v = 1;
					lx_mode = M_OP2;
				end else if (is_dig(c)) begin
					lx_nflags = 0;
					lx_mode = M_NUM;
					val_out(c[7:0]);
				end else if (is_let(c) || c == "_") begin
					lx_word = {32'd0, c[7:0]};
					lx_len = 1;
					lx_mode = M_WORD;
				end else if (glyph_kind(c) != K_NONE) close_tok(glyph_kind(c));
				else raise(E_BAD_CHAR);
				return 0;
			end
			M_SLASH: begin
				if (c == "/") begin lx_mode = M_LCOM; return 0; end
				if (c == "*") begin lx_mode = M_BCOM; return 0; end
				close_tok(K_SLASH); back_to_gap(); return 1;
			end
			M_LCOM: begin
				if (c < 0) begin back_to_gap(); return 1; end
				if (c == "\n") back_to_gap();
				return 0;
			end
			M_BCOM, M_BSTAR: begin
				if (c < 0) begin raise(E_OPEN_COM); return 0; end
				if (lx_mode == M_BSTAR && c == "/") back_to_gap();
				else lx_mode = (c == "*") ? M_BSTAR : M_BCOM;
				return 0;
			end
			M_LT: begin
				if (c == "?") begin
					lx_word = 0; lx_len = 0; lx_mode = M_TAG;
					return 0;
				end
				if (c == "=") begin close_tok(K_LE); back_to_gap(); return 0; end
				close_tok(K_LT); back_to_gap(); return 1;
			end
			M_TAG: begin
				if (is_let(c)) begin
					if (lx_len >= 3) begin raise(E_BAD_TAG); return 0; end
					lx_word = {lx_word[31:0], c[7:0]};
					lx_len++;
					return 0;
				end
				if (lx_len == 3 && lx_word == TAG_PHP) begin
					close_tok(K_OPEN); back_to_gap(); return 1;
				end
				raise(E_BAD_TAG);
				return 0;
			end
			M_QUEST: begin
				if (c == ">") begin close_tok(K_CLOSE); back_to_gap(); end
				else raise(E_BAD_CHAR);
				return 0;
			end
			M_STR: begin
				if (c < 0 || c == (lx_single ? "'" : "\"")) begin
					close_tok(K_STRING); back_to_gap();
					return c < 0;
				end
				if (c == "\\") lx_mode = M_STRESC;
				else val_out(c[7:0]);
				return 0;
			end
			M_STRESC: begin
				if (c < 0) begin close_tok(K_STRING); back_to_gap(); return 1; end
				lx_mode = M_STR;
				if (lx_single) begin
					if (c == "'" || c == "\\") begin val_out(c[7:0]); return 0; end
				end else begin
					if (c == "n") begin val_out(8'd10); return 0; end
					if (c == "t") begin val_out(8'd9); return 0; end
					if (c == "r") begin val_out(8'd13); return 0; end
					if (c == "\"" || c == "\\" || c == "$") begin
						val_out(c[7:0]);
						return 0;
					end
				end
				val_out("\\");
				val_out(c[7:0]);
				return 0;
			end
			M_NUM: begin
				if (is_dig(c)) begin val_out(c[7:0]); return 0; end
				if (c == "." && lx_nflags == 0) begin
					lx_nflags[0] = 1; val_out("."); return 0;
				end
				if ((c == "e" || c == "E") && !lx_nflags[1]) begin
					lx_nflags[1] = 1; val_out(c[7:0]); lx_mode = M_NUMEXP;
					return 0;
				end
				close_tok(lx_nflags != 0 ? K_FLOAT : K_INT); back_to_gap();
				return 1;
			end
			M_NUMEXP: begin
				lx_mode = M_NUM;
				if (c == "+" || c == "-") begin val_out(c[7:0]); return 0; end
				return 1;
			end
			M_DOLLAR: begin
				lx_len = 0;
				if (c == "$") begin lx_mode = M_DYN; return 0; end
				lx_mode = M_VAR;
				return 1;
			end
			M_VAR, M_DYN: begin
				if (is_idc(c)) begin val_out(c[7:0]); return 0; end
				if (lx_len == 0) begin raise(E_EMPTY); return 0; end
				close_tok(lx_mode == M_DYN ? K_DYNVAR : K_VAR); back_to_gap();
				return 1;
			end
			M_WORD: begin
				if (is_idc(c)) begin
					if (lx_len >= 5) begin raise(E_UNKNOWN); return 0; end
					lx_word = {lx_word[31:0], c[7:0]};
					lx_len++;
					return 0;
				end
				k = K_NONE;
				if (lx_word == KW_ECHO) k = K_ECHO;
				if (lx_word == KW_IF) k = K_IF;
				if (lx_word == KW_ELSE) k = K_ELSE;
				if (lx_word == KW_WHILE) k = K_WHILE;
				if (lx_word == KW_FOR) k = K_FOR;
				if (k == K_NONE) begin raise(E_UNKNOWN); return 0; end
				close_tok(k); back_to_gap();
				return 1;
			end
			M_EQ1: begin
				if (c == "=") begin lx_mode = M_EQ2; return 0; end
				close_tok(K_ASSIGN); back_to_gap(); return 1;
			end
			M_EQ2: begin
				if (c == "=") begin close_tok(K_IDENT); back_to_gap(); return 0; end
				close_tok(K_EQ); back_to_gap(); return 1;
			end
			M_OP2: begin
				if (c == "=") begin
					close_tok(pair_kind(lx_held, 1)); back_to_gap(); return 0;
				end
				close_tok(pair_kind(lx_held, 0)); back_to_gap(); return 1;
			end
			default: begin
				if (c < 0) add_res(8'd0, 0, 1, K_END, lx_line, E_NONE);
				return 0;
			end
		endcase
	endfunction

	// works out the results of one accepted source byte and queues them
	function void lex_byte(logic [7:0] b, logic eoi);
		int c;
		step_res.delete();
		if (lx_halted) return;
		if (eoi) c = -1;
		else begin
			c = b;
			if (lx_mode == M_DONE) return;
			if (c == 10 && lx_line < LINE_TOP) lx_line++;
		end
		for (int p = 0; p < 4; p++)
			if (!lex_pass(c) || lx_halted) break;
		if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_step = 1'b1;
		foreach (step_res[i]) tokens_due.push_back(step_res[i]);
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_seen, what, got, want);
		errors++;
	endtask

	// stimulus helpers
	function void put(logic [7:0] b, logic eoi = 0);
		src_t s;
		s.ch = b;
		s.eoi = eoi;
		src_q.push_back(s);
	endfunction

	function void put_text(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function logic [7:0] ident_char();
		case ($urandom_range(0, 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			default: return "_";
		endcase
	endfunction

	function void put_digits(int n);
		repeat (n) put(8'("0" + $urandom_range(0, 9)));
	endfunction

	function void put_string();
		bit sq;
		logic [7:0] b;
		logic [7:0] q;
		sq = 1'($urandom_range(0, 1));
		q = sq ? "'" : "\"";
		put(q);
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 3) == 0) begin
				put("\\");
				case ($urandom_range(0, 3))
					0: put(q);
					1: put("\\");
					2: put(sq ? "n" : "$");
					default: put(8'($urandom_range(0, 255)));
				endcase
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == q || b == "\\") b = "x";
				put(b);
			end
		end
		put(q);
	endfunction

	function automatic void put_token(bit glued);
		string ops[18] = '{"=", "+=", "-=", ".=", "+", "-", "*", "/", "%", ".",
			"==", "!=", "===", "<", ">", "<=", ">=", "!"};
		string kws[5] = '{"echo", "if", "else", "while", "for"};
		string glue = ";,(){}%";
		logic [7:0] b;
		if (glued) begin
			put(glue[$urandom_range(0, 6)]);
			return;
		end
		case ($urandom_range(0, 13))
			0: put_text("<?php");
			1: put_text("?>");
			2: put_digits($urandom_range(1, 6));
			3: begin
				put_digits($urandom_range(1, 3));
				if ($urandom_range(0, 1)) begin put("."); put_digits($urandom_range(0, 3)); end
				if ($urandom_range(0, 1)) begin
					put($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: put("+");
						1: put("-");
						default: ;
					endcase
					put_digits($urandom_range(0, 2));
				end
			end
			4, 5: put_string();
			6: begin
				put("$");
				repeat ($urandom_range(1, 8)) put(ident_char());
			end
			7: begin
				put_text("$$");
				repeat ($urandom_range(1, 5)) put(ident_char());
			end
			8: put_text(kws[$urandom_range(0, 4)]);
			9, 10: put_text(ops[$urandom_range(0, 17)]);
			11: put(glue[$urandom_range(0, 5)]);
			12: begin
				if ($urandom_range(0, 1)) put_text("//"); else put("#");
				repeat ($urandom_range(0, 8)) begin
					b = 8'($urandom_range(0, 255));
					put(b == 10 ? 8'h7F : b);
				end
				put(8'd10);
			end
			default: begin
				put_text("/*");
				repeat ($urandom_range(0, 8)) begin
					b = 8'($urandom_range(0, 255));
					put(b == "/" ? "*" : b);
				end
				put_text("*/");
			end
		endcase
	endfunction

	function automatic void put_space();
		string ws = " \t\n\r\n  ";
		repeat ($urandom_range(1, 2)) put(ws[$urandom_range(0, 6)]);
	endfunction

	function int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// source driver
	always @(posedge clk or negedge arst_n) begin
		src_t s;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			input_byte <= 8'd0;
			end_of_input <= 1'b0;
			in_gap <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				lex_byte(input_byte, end_of_input);
				bytes_sent++;
			end
			if (!byte_valid || !byte_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					byte_valid <= 1'b0;
				end else if (src_q.size() > 0) begin
					s = src_q.pop_front();
					input_byte <= s.ch;
					end_of_input <= s.eoi;
					byte_valid <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the input side backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (!holdoff_done && bytes_sent >= 200) begin
				holdoff_done <= 1;
				holdoff_cnt <= 300;
			end else if (holdoff_cnt > 0) begin
				holdoff_cnt <= holdoff_cnt - 1;
			end
		end
	end

	// token monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		res_t r;
		if (!arst_n) begin
			token_stall <= 1'b0;
		end else begin
			if (token_valid && !token_stall) begin
				if (tokens_due.size() == 0) begin
					report("unexpected transfer", token_kind, 0);
				end else begin
					r = tokens_due.pop_front();
					if (value_byte !== r.value_byte) report("value_byte", value_byte, r.value_byte);
					if (has_byte !== r.has_byte) report("has_byte", has_byte, r.has_byte);
					if (token_done !== r.token_done) report("token_done", token_done, r.token_done);
					if (token_kind !== r.token_kind) report("token_kind", token_kind, r.token_kind);
					if (token_line !== r.token_line) report("token_line", token_line, r.token_line);
					if (error_code !== r.error_code) report("error_code", error_code, r.error_code);
					if (last_of_step !== r.last_of_step)
						report("last_of_step", last_of_step, r.last_of_step);
					if (r.token_done) tokens_seen++;
				end
				results_seen++;
			end
			if (holdoff_cnt > 0) begin
				token_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				token_stall <= 1'b1;
			end else begin
				out_gap <= pick_gap();
				token_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int tail;
		lx_mode = M_GAP; lx_held = 0; lx_held_v = 0; lx_line = 1; lx_start = 1;
		lx_word = 0; lx_len = 0; lx_nflags = 0; lx_single = 0; lx_halted = 0;
		arst_n = 1'b0;

		// directed: tag, dynamic variable, compound ops, float with exponent, escapes
		put_text("<?php $$v_1.=0.5E-3;'\\'\\\\'\"\\n\\q\"#c\n");
		put_text("echo!==1e+9?>");
		put(8'd10);
		while (src_q.size() < 420) begin
			if ($urandom_range(0, 4) == 0) begin
				put_token(0);
				put_token(1);
			end else begin
				put_token(0);
			end
			put_space();
		end

		// ending: one way to close the stream, errors halt so only one fits
		tail = $urandom_range(0, 5);
		case (tail)
			0: begin put_text("#end"); put(8'd0, 1'b1); put_text("ab"); put(8'd0, 1'b1); end
			1: begin put_text("\"open\\"); put(8'd0, 1'b1); put(8'd0, 1'b1); end
			2: begin put_text("/* never closed *"); put(8'd0, 1'b1); put(8'd0, 1'b1); end
			3: begin put_text("<?pxp x"); put(8'd0, 1'b1); end
			4: begin put_text("$ ;"); put(8'd0, 1'b1); end
			default: begin
				put("'");
				repeat (VALUE_LEN + 2) put(8'("a" + $urandom_range(0, 25)));
				put(8'd0, 1'b1);
			end
		endcase
		if ($urandom_range(0, 1)) begin put_text("zzzzzz "); put(8'd0, 1'b1); end
		if ($urandom_range(0, 1)) begin put_text("?x"); put(8'd0, 1'b1); end
		if ($urandom_range(0, 1)) begin put(8'hA7); put(8'd0, 1'b1); end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// a stretch with no idling on either side
		wait (bytes_sent >= 60);
		calm = 1;
		wait (bytes_sent >= 130);
		calm = 0;

		wait (src_q.size() == 0 && !byte_valid);
		wait (tokens_due.size() == 0);
		repeat (50) @(posedge clk);

		$display("sent %0d source bytes, checked %0d results with %0d closed tokens",
			bytes_sent, results_seen, tokens_seen);
		$display("stream ending variant %0d, one long receiver hold-off applied", tail);
		if (errors == 0 && tokens_due.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== script_subset_tokenizer.f =====
+incdir+src
src/sst_pkg.sv
src/sst_front.sv
src/sst_back.sv
src/script_subset_tokenizer.sv
verif/tb_top.sv
